// ===== rtl/core/depth_to_color_gradient_unit_defines.svh =====
// shared assertion macros for the depth colour unit
`ifndef DEPTH_TO_COLOR_GRADIENT_UNIT_DEFINES_SVH
`define DEPTH_TO_COLOR_GRADIENT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, held off during rst
`define DCG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define DCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dcg_pkg.sv =====
`timescale 1ns / 1ps
package dcg_pkg;

  localparam int DEPTH_W = 16;
  localparam int CH_W    = 8;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX = 2'd1;
  localparam logic [1:0] REG_INVALID   = 2'd2;

  localparam logic [DEPTH_W-1:0] RANGE_MIN_RESET = 16'd500;
  localparam logic [DEPTH_W-1:0] RANGE_MAX_RESET = 16'd4000;
  localparam logic [DEPTH_W-1:0] INVALID_RESET   = 16'd0;

  // gradient segments, the integer part of the position
  localparam logic [2:0] SEG_BLUE_CYAN    = 3'd0;
  localparam logic [2:0] SEG_CYAN_GREEN   = 3'd1;
  localparam logic [2:0] SEG_GREEN_YELLOW = 3'd2;
  localparam logic [2:0] SEG_YELLOW_RED   = 3'd3;

  typedef struct packed {
    logic valid;
    logic black;
  } ctl_t;

endpackage

// ===== rtl/core/dcg_div_cell.sv =====
`timescale 1ns / 1ps
module dcg_div_cell
  import dcg_pkg::*;
#(
  parameter int QB = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl_in,
  input  logic [DEPTH_W-1:0] span_in,
  input  logic [DEPTH_W-1:0] rem_in,
  input  logic [QB-1:0]      num_in,
  input  logic [QB-1:0]      quot_in,
  output ctl_t               ctl,
  output logic [DEPTH_W-1:0] span,
  output logic [DEPTH_W-1:0] rem,
  output logic [QB-1:0]      num,
  output logic [QB-1:0]      quot
);

  logic [DEPTH_W:0]   trial;
  logic [DEPTH_W:0]   span_ext;
  logic [DEPTH_W:0]   trial_sub;
  logic               take;
  logic [DEPTH_W-1:0] rem_next;

  // one restoring step: bring down the next numerator bit, subtract if it fits
  assign trial     = {rem_in, num_in[QB-1]};
  assign span_ext  = {1'b0, span_in};
  assign trial_sub = trial - span_ext;
  assign take      = (trial >= span_ext);
  assign rem_next  = take ? trial_sub[DEPTH_W-1:0] : trial[DEPTH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    span <= span_in;
    rem  <= rem_next;
    num  <= {num_in[QB-2:0], 1'b0};
    quot <= {quot_in[QB-2:0], take};
  end

endmodule

// ===== rtl/core/dcg_shade.sv =====
`timescale 1ns / 1ps
module dcg_shade
  import dcg_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctl_t                       ctl_in,
  input  logic [FRACTION_BITS+2:0]   pos_in,
  output logic                       done,
  output logic [CH_W-1:0]            red,
  output logic [CH_W-1:0]            green,
  output logic [CH_W-1:0]            blue
);

  localparam int VW = FRACTION_BITS + 1;
  localparam logic [VW-1:0] ONE = VW'(1) << FRACTION_BITS;

  logic [2:0]    seg;
  logic [VW-1:0] frac;
  logic [VW-1:0] frac_inv;
  logic [VW-1:0] r_lvl;
  logic [VW-1:0] g_lvl;
  logic [VW-1:0] b_lvl;

  // floor(255 * v / ONE), 255 * v formed as v * 256 - v
  function automatic logic [CH_W-1:0] to_byte(input logic [VW-1:0] v);
    logic [VW+CH_W-1:0] prod;
    prod = {v, {CH_W{1'b0}}} - {{CH_W{1'b0}}, v};
    return prod[FRACTION_BITS+CH_W-1:FRACTION_BITS];
  endfunction

  assign seg      = pos_in[FRACTION_BITS+2:FRACTION_BITS];
  assign frac     = {1'b0, pos_in[FRACTION_BITS-1:0]};
  assign frac_inv = ONE - frac;

  always_comb begin
    unique case (seg)
      SEG_BLUE_CYAN: begin
        r_lvl = '0;    g_lvl = frac;     b_lvl = ONE;
      end
      SEG_CYAN_GREEN: begin
        r_lvl = '0;    g_lvl = ONE;      b_lvl = frac_inv;
      end
      SEG_GREEN_YELLOW: begin
        r_lvl = frac;  g_lvl = ONE;      b_lvl = '0;
      end
      SEG_YELLOW_RED: begin
        r_lvl = ONE;   g_lvl = frac_inv; b_lvl = '0;
      end
      default: begin
        // last stop, pure red
        r_lvl = ONE;   g_lvl = '0;       b_lvl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.black) begin
      red   <= '0;
      green <= '0;
      blue  <= '0;
    end else begin
      red   <= to_byte(r_lvl);
      green <= to_byte(g_lvl);
      blue  <= to_byte(b_lvl);
    end
  end

endmodule

// ===== rtl/core/depth_to_color_gradient_unit.sv =====
// channel   ports                                        handshake
// request   start, depth_sample                          start & !busy
// result    done, red, green, blue                       done, one cycle
// config    psel, penable, pwrite, paddr, pwdata,        psel & penable & pwrite
//           prdata, pready
//
// a request is taken every cycle; busy is high only while rst is held
// the pipeline is one division cell per quotient bit
// (FRACTION_BITS + 3 cells) plus the colour output register
// the receiver cannot stall, each result shows on done for one cycle
// rst clears the pipeline valid bits and loads the register reset values
`timescale 1ns / 1ps
module depth_to_color_gradient_unit
  import dcg_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DEPTH_W-1:0] depth_sample,
  output logic               busy,
  output logic               done,
  output logic [CH_W-1:0]    red,
  output logic [CH_W-1:0]    green,
  output logic [CH_W-1:0]    blue,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int QB = FRACTION_BITS + 3;

  logic [DEPTH_W-1:0] range_min_mm;
  logic [DEPTH_W-1:0] range_max_mm;
  logic [DEPTH_W-1:0] invalid_code;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min_mm <= RANGE_MIN_RESET;
      range_max_mm <= RANGE_MAX_RESET;
      invalid_code <= INVALID_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RANGE_MIN: range_min_mm <= pwdata[DEPTH_W-1:0];
        REG_RANGE_MAX: range_max_mm <= pwdata[DEPTH_W-1:0];
        REG_INVALID:   invalid_code <= pwdata[DEPTH_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RANGE_MIN: prdata = {{(DATA_W-DEPTH_W){1'b0}}, range_min_mm};
      REG_RANGE_MAX: prdata = {{(DATA_W-DEPTH_W){1'b0}}, range_max_mm};
      REG_INVALID:   prdata = {{(DATA_W-DEPTH_W){1'b0}}, invalid_code};
      default:       prdata = '0;
    endcase
  end

  assign busy = rst;

  // front end: clamp and set up the division (d - min) * 4 * ONE / span
  logic [DEPTH_W-1:0] clamped;
  logic [DEPTH_W-1:0] offset;
  ctl_t               ctl_front;

  always_comb begin
    if (depth_sample < range_min_mm) begin
      clamped = range_min_mm;
    end else if (depth_sample > range_max_mm) begin
      clamped = range_max_mm;
    end else begin
      clamped = depth_sample;
    end
  end

  assign offset          = clamped - range_min_mm;
  assign ctl_front.valid = start & ~busy;
  assign ctl_front.black = (depth_sample == invalid_code) |
                           (range_max_mm <= range_min_mm);

  ctl_t               ctl_c  [QB+1];
  logic [DEPTH_W-1:0] span_c [QB+1];
  logic [DEPTH_W-1:0] rem_c  [QB+1];
  logic [QB-1:0]      num_c  [QB+1];
  logic [QB-1:0]      quot_c [QB+1];

  // quotient fits in QB bits, so the top of the numerator starts as remainder
  assign ctl_c[0]  = ctl_front;
  assign span_c[0] = range_max_mm - range_min_mm;
  assign rem_c[0]  = {1'b0, offset[DEPTH_W-1:1]};
  assign num_c[0]  = {offset[0], {(QB-1){1'b0}}};
  assign quot_c[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    dcg_div_cell #(
      .QB(QB)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_c[i]),
      .span_in (span_c[i]),
      .rem_in  (rem_c[i]),
      .num_in  (num_c[i]),
      .quot_in (quot_c[i]),
      .ctl     (ctl_c[i+1]),
      .span    (span_c[i+1]),
      .rem     (rem_c[i+1]),
      .num     (num_c[i+1]),
      .quot    (quot_c[i+1])
    );
  end

  dcg_shade #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_shade (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_c[QB]),
    .pos_in (quot_c[QB]),
    .done   (done),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

endmodule

// ===== rtl/core/dcg_checker.sv =====
`timescale 1ns / 1ps
`include "depth_to_color_gradient_unit_defines.svh"
module dcg_checker
  import dcg_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input logic [CH_W-1:0] red,
  input logic [CH_W-1:0] green,
  input logic [CH_W-1:0] blue
);

  localparam int LAT = FRACTION_BITS + 4;

  logic px_black;
  logic px_full;

  assign px_black = (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);
  assign px_full  = (red == 8'd255) || (green == 8'd255) || (blue == 8'd255);

  // every request yields exactly one result after the fixed latency
  `DCG_ASSERT_SAME(a_req_gives_result, start && !busy, ##LAT done, "request without result")
  `DCG_ASSERT_SAME(a_result_has_req, done, $past(start && !busy, LAT), "result without request")
  // on this gradient red and blue are never both lit
  `DCG_ASSERT_SAME(a_no_magenta, done, red == 8'd0 || blue == 8'd0, "red and blue both set")
  // some channel is saturated unless the pixel is black
  `DCG_ASSERT_SAME(a_saturated, done, px_full || px_black, "no saturated channel")

endmodule

bind depth_to_color_gradient_unit dcg_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_dcg_checker (.*);

// ===== tb/sv/tb_depth_to_color_gradient_unit.sv =====
`timescale 1ns / 1ps
module tb_depth_to_color_gradient_unit;
  import dcg_pkg::*;

  localparam int FRACTION_BITS = 8;
  localparam int LATENCY = FRACTION_BITS + 4;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // first probes run under the reset range of 500 .. 4000 mm
  localparam logic [DEPTH_W-1:0] RESET_PROBE [14] = '{
    16'd0, 16'd1, 16'd499, 16'd500, 16'd501, 16'd1374, 16'd1375,
    16'd2250, 16'd3125, 16'd3999, 16'd4000, 16'd4001, 16'd65535, 16'd2000
  };

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  class depth_colour_checker;
    logic [DEPTH_W-1:0] range_min;
    logic [DEPTH_W-1:0] range_max;
    logic [DEPTH_W-1:0] invalid_code;
    pixel_t expected_pixels[$];
    int fails;

    function new();
      range_min = RANGE_MIN_RESET;
      range_max = RANGE_MAX_RESET;
      invalid_code = INVALID_RESET;
      fails = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_RANGE_MIN: range_min = value[DEPTH_W-1:0];
        REG_RANGE_MAX: range_max = value[DEPTH_W-1:0];
        REG_INVALID:   invalid_code = value[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CH_W-1:0] to_channel(longint unsigned level);
      longint unsigned scaled;
      scaled = (level * 255) >> FRACTION_BITS;
      return scaled[CH_W-1:0];
    endfunction

    function void note_sample(logic [DEPTH_W-1:0] sample);
      longint unsigned one, span, depth, pos, frac;
      longint unsigned r, g, b;
      pixel_t px;
      one = 64'd1 << FRACTION_BITS;
      r = 0;
      g = 0;
      b = 0;
      if (sample != invalid_code && range_max > range_min) begin
        depth = 64'(sample);
        if (depth < 64'(range_min)) depth = 64'(range_min);
        if (depth > 64'(range_max)) depth = 64'(range_max);
        span = 64'(range_max) - 64'(range_min);
        pos = (((depth - 64'(range_min)) * 4) << FRACTION_BITS) / span;
        frac = pos & (one - 1);
        case (pos >> FRACTION_BITS)
          SEG_BLUE_CYAN: begin
            g = frac;
            b = one;
          end
          SEG_CYAN_GREEN: begin
            g = one;
            b = one - frac;
          end
          SEG_GREEN_YELLOW: begin
            r = frac;
            g = one;
          end
          SEG_YELLOW_RED: begin
            r = one;
            g = one - frac;
          end
          default: begin
            r = one;
          end
        endcase
      end
      px.red = to_channel(r);
      px.green = to_channel(g);
      px.blue = to_channel(b);
      expected_pixels.push_back(px);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("colour result with no request waiting: %0d %0d %0d",
               got.red, got.green, got.blue);
        fails++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        fails++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        fails++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        fails++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic [DEPTH_W-1:0] depth_sample;
  logic               busy;
  logic               done;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  depth_colour_checker pixel_check = new();

  depth_to_color_gradient_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .depth_sample(depth_sample),
    .busy(busy),
    .done(done),
    .red(red),
    .green(green),
    .blue(blue),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done) pixel_check.check_pixel(pixel_t'{red, green, blue});
  end

  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pixel_check.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [DEPTH_W-1:0] sample, input int gap);
    start <= 1'b1;
    depth_sample <= sample;
    do @(posedge clk); while (busy);
    pixel_check.note_sample(sample);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pixel_check.expected_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int lo, hi, near;
    int unsigned sel;
    lo = int'(pixel_check.range_min);
    hi = int'(pixel_check.range_max);
    sel = $urandom_range(0, 99);
    if (sel < 10) return pixel_check.invalid_code;
    if (sel < 25) begin
      // just around either end of the range
      near = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 4)) - 2;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      return near[DEPTH_W-1:0];
    end
    if (sel < 80 && hi > lo) return DEPTH_W'($urandom_range(hi, lo));
    return DEPTH_W'($urandom());
  endfunction

  task automatic random_config();
    int unsigned lo, hi, inv;
    case ($urandom_range(0, 4))
      0: begin
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 65535);
      end
      1: begin
        lo = $urandom_range(0, 60000);
        hi = lo + $urandom_range(1, 5000);
      end
      2: begin
        lo = 0;
        hi = 65535;
      end
      3: begin
        lo = $urandom_range(0, 65531);
        hi = lo + $urandom_range(1, 4);
      end
      default: begin
        // empty range, max at or below min
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, lo);
      end
    endcase
    inv = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(hi, lo);
    apb_write(REG_RANGE_MIN, ($urandom() & 32'hFFFF_0000) | lo);
    apb_write(REG_RANGE_MAX, ($urandom() & 32'hFFFF_0000) | hi);
    apb_write(REG_INVALID, ($urandom() & 32'hFFFF_0000) | inv);
    if ($urandom_range(0, 3) == 0) apb_write(REG_UNUSED, $urandom());
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    depth_sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (RESET_PROBE[i]) send_sample(RESET_PROBE[i], $urandom_range(0, 4));

    // top code marks no measurement, so zero becomes a real depth
    drain();
    apb_write(REG_INVALID, 32'hFFFF_FFFF);
    send_sample(16'd65535, $urandom_range(0, 4));
    send_sample(16'd0, $urandom_range(0, 4));

    // max equal to min, then max below min
    drain();
    apb_write(REG_RANGE_MIN, 32'hA5A5_03E8);
    apb_write(REG_RANGE_MAX, 32'h0000_03E8);
    send_sample(16'd1000, $urandom_range(0, 4));
    send_sample(16'd999, $urandom_range(0, 4));
    drain();
    apb_write(REG_RANGE_MIN, 32'd3000);
    apb_write(REG_RANGE_MAX, 32'd100);
    send_sample(16'd50, $urandom_range(0, 4));
    send_sample(16'd2000, $urandom_range(0, 4));

    // full span, plus a write to the hole in the map which must be dropped
    drain();
    apb_write(REG_RANGE_MIN, 32'd0);
    apb_write(REG_RANGE_MAX, 32'd65535);
    apb_write(REG_UNUSED, 32'h0000_1234);
    send_sample(16'd0, $urandom_range(0, 4));
    send_sample(16'd32768, $urandom_range(0, 4));
    send_sample(16'd65534, $urandom_range(0, 4));
    send_sample(16'd65535, $urandom_range(0, 4));

    // narrowest span
    drain();
    apb_write(REG_RANGE_MAX, 32'd1);
    apb_write(REG_INVALID, 32'd0);
    send_sample(16'd0, $urandom_range(0, 4));
    send_sample(16'd1, $urandom_range(0, 4));
    send_sample(16'd2, $urandom_range(0, 4));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      random_config();
      for (int n = 0; n < 50; n++) begin
        // hold requests back until the pipeline is empty
        if (ph == 1 && n == 25) drain();
        send_sample(pick_depth(), (ph % 3 == 2) ? 0 : $urandom_range(0, 4));
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (pixel_check.fails == 0 && pixel_check.expected_pixels.size() == 0) begin
      $display("tb_depth_to_color_gradient_unit OK");
    end else begin
      $display("tb_depth_to_color_gradient_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb_depth_to_color_gradient_unit NOT OK");
    $finish;
  end

endmodule
